// ===== hdl/ssw_pkg.sv =====
// ----------------------------------------------------------------------------
// ssw_pkg - shared types and constants of the snake slice walker
// Register indexes, counter widths, limit clamping and the cell control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssw_pkg;

  // Fixed geometry of the walk
  localparam int unsigned MaxDims   = 4;
  localparam int unsigned MaxSlices = 1024;
  localparam int unsigned CoordW    = 11;
  localparam int unsigned NumCells  = MaxDims + 1;  // common counter + dimension counters
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned DimsW     = 3;

  typedef logic [CoordW-1:0] coord_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_DIMS     = 3'd0,
    REG_LIMIT_FIRST  = 3'd1,
    REG_LIMIT_SECOND = 3'd2,
    REG_LIMIT_THIRD  = 3'd3,
    REG_LIMIT_FOURTH = 3'd4,
    REG_COMMON_LIMIT = 3'd5,
    REG_SNAKE_ENABLE = 3'd6,
    REG_CHANGE_POS   = 3'd7
  } reg_idx_e;

  // Control word handed from the top level to each counter cell
  typedef struct packed {
    logic clear;     // restart: back to zero, counting upward
    logic step;      // carry into this cell
    logic snake;     // serpentine turnaround at wrap
    logic load_end;  // whole walk wrapped: park at the limit
  } cell_ctrl_t;

  // Saturate a limit register to 1..MaxSlices
  function automatic coord_t clamp_limit(input coord_t v);
    coord_t r;
    if (v == '0) begin
      r = coord_t'(1);
    end else if (v > coord_t'(MaxSlices)) begin
      r = coord_t'(MaxSlices);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/snake_slice_walker_core.sv =====
// ----------------------------------------------------------------------------
// snake_slice_walker_core - serpentine nested-loop slice walker
// A chain of counter cells (common counter first, then up to four dimension
// counters) advances one slice position per accepted word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | in_valid_i / in_ready_o  | restart_walk_i
//  out     | output    | out_valid_o / out_ready_i| coord_*_o, common_coord_o,
//          |           |                          | slice_changed_o, walk_ended_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One word per cycle while the output is drained: the carry ripples through
//  the five cells in the cycle the word is accepted and the result lands in
//  the output register, which shows it valid in the cycle after the accept.
//  The input is ready whenever the output register is empty or being drained.
//  Reset clears the walk and loads the register defaults; cfg is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module snake_slice_walker_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [ssw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire  [ssw_pkg::CfgDataW-1:0]     cfg_data_i,
  // input words
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              restart_walk_i,
  // output words
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [ssw_pkg::CoordW-1:0]       coord_first_o,
  output logic [ssw_pkg::CoordW-1:0]       coord_second_o,
  output logic [ssw_pkg::CoordW-1:0]       coord_third_o,
  output logic [ssw_pkg::CoordW-1:0]       coord_fourth_o,
  output logic [ssw_pkg::CoordW-1:0]       common_coord_o,
  output logic                             slice_changed_o,
  output logic                             walk_ended_o
);

  localparam int unsigned NCells = ssw_pkg::NumCells;
  localparam int unsigned NDims  = ssw_pkg::MaxDims;

  // Configuration registers
  logic [ssw_pkg::DimsW-1:0] num_dims_q;
  ssw_pkg::coord_t           limit_q [NDims];
  ssw_pkg::coord_t           common_limit_q;
  logic                      snake_q;
  logic [ssw_pkg::DimsW-1:0] chg_pos_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q     <= ssw_pkg::DimsW'(2);
      for (int k = 0; k < NDims; k++) limit_q[k] <= ssw_pkg::coord_t'(1);
      common_limit_q <= ssw_pkg::coord_t'(1);
      snake_q        <= 1'b0;
      chg_pos_q      <= ssw_pkg::DimsW'(1);
    end else if (cfg_valid_i) begin
      case (ssw_pkg::reg_idx_e'(cfg_index_i))
        ssw_pkg::REG_NUM_DIMS:     num_dims_q     <= cfg_data_i[ssw_pkg::DimsW-1:0];
        ssw_pkg::REG_LIMIT_FIRST:  limit_q[0]     <= cfg_data_i;
        ssw_pkg::REG_LIMIT_SECOND: limit_q[1]     <= cfg_data_i;
        ssw_pkg::REG_LIMIT_THIRD:  limit_q[2]     <= cfg_data_i;
        ssw_pkg::REG_LIMIT_FOURTH: limit_q[3]     <= cfg_data_i;
        ssw_pkg::REG_COMMON_LIMIT: common_limit_q <= cfg_data_i;
        ssw_pkg::REG_SNAKE_ENABLE: snake_q        <= cfg_data_i[0];
        ssw_pkg::REG_CHANGE_POS:   chg_pos_q      <= cfg_data_i[ssw_pkg::DimsW-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings
  logic [ssw_pkg::DimsW-1:0] n_used;
  logic                      snake_eff;
  ssw_pkg::coord_t           cell_lim [NCells];

  always_comb begin
    if (num_dims_q == '0) begin
      n_used = ssw_pkg::DimsW'(1);
    end else if (num_dims_q > ssw_pkg::DimsW'(NDims)) begin
      n_used = ssw_pkg::DimsW'(NDims);
    end else begin
      n_used = num_dims_q;
    end
  end

  assign snake_eff   = snake_q & (n_used >= ssw_pkg::DimsW'(2));
  assign cell_lim[0] = ssw_pkg::clamp_limit(common_limit_q);

  // Handshake and step qualification
  logic accept;
  logic step_go;
  logic done_q, done_d;
  logic out_valid_q;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign step_go    = accept & ~restart_walk_i & ~done_q;

  // Counter chain: cell 0 is the common counter, cell k+1 is dimension k
  ssw_pkg::cell_ctrl_t ctrl  [NCells];
  logic [NCells-1:0]   carry;
  logic [NCells-1:0]   en;
  ssw_pkg::coord_t     coord_next [NCells];
  logic                all_wrap;

  assign en[0] = step_go;

  for (genvar k = 0; k < NDims; k++) begin : g_en
    assign cell_lim[k+1] = ssw_pkg::clamp_limit(limit_q[k]);
    assign en[k+1]       = carry[k] & (ssw_pkg::DimsW'(k) < n_used);
  end

  // Walk ends when the last dimension in use wraps
  always_comb begin
    all_wrap = 1'b0;
    for (int k = 0; k < NDims; k++) begin
      if (ssw_pkg::DimsW'(k + 1) == n_used) all_wrap = carry[k+1];
    end
  end

  for (genvar c = 0; c < NCells; c++) begin : g_cell
    assign ctrl[c].clear    = accept & restart_walk_i;
    assign ctrl[c].step     = en[c];
    assign ctrl[c].snake    = (c <= 1) ? snake_eff : 1'b0;
    assign ctrl[c].load_end = all_wrap;

    ssw_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl[c]),
      .limit_i      (cell_lim[c]),
      .carry_o      (carry[c]),
      .coord_next_o (coord_next[c])
    );
  end

  // Slice change: common counter spans slices, or the watched counter stepped
  logic changed;
  always_comb begin
    changed = cell_lim[0] > ssw_pkg::coord_t'(1);
    for (int k = 0; k < NDims; k++) begin
      if (chg_pos_q == ssw_pkg::DimsW'(k) && en[k+1]) changed = 1'b1;
    end
    changed = changed & step_go;
  end

  always_comb begin
    done_d = done_q;
    if (accept && restart_walk_i) begin
      done_d = 1'b0;
    end else if (step_go && all_wrap) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= done_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register; unused dimensions read as zero
  ssw_pkg::coord_t out_coord_q [NDims];
  ssw_pkg::coord_t out_common_q;
  logic            out_changed_q;
  logic            out_ended_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < NDims; k++) begin
        out_coord_q[k] <= (ssw_pkg::DimsW'(k) < n_used) ? coord_next[k+1] : '0;
      end
      out_common_q  <= coord_next[0];
      out_changed_q <= changed;
      out_ended_q   <= done_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign coord_first_o   = out_coord_q[0];
  assign coord_second_o  = out_coord_q[1];
  assign coord_third_o   = out_coord_q[2];
  assign coord_fourth_o  = out_coord_q[3];
  assign common_coord_o  = out_common_q;
  assign slice_changed_o = out_changed_q;
  assign walk_ended_o    = out_ended_q;

endmodule

`default_nettype wire

// ===== hdl/ssw_cell.sv =====
// ----------------------------------------------------------------------------
// ssw_cell - one counter cell of the walker chain
// Holds a coordinate and its direction flag, steps on carry-in and hands its
// wrap on to the next cell as carry-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssw_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  ssw_pkg::cell_ctrl_t  ctrl_i,
  input  ssw_pkg::coord_t      limit_i,
  output logic                 carry_o,
  output ssw_pkg::coord_t      coord_next_o
);

  ssw_pkg::coord_t         coord_q, coord_d;
  logic                    rev_q, rev_d;
  ssw_pkg::coord_t         lim_m1;
  ssw_pkg::coord_t         dec;
  logic [ssw_pkg::CoordW:0] inc;
  ssw_pkg::coord_t         step_coord;
  logic                    step_rev;
  logic                    wrap;

  assign lim_m1 = limit_i - ssw_pkg::coord_t'(1);
  assign dec    = coord_q - ssw_pkg::coord_t'(1);
  assign inc    = {1'b0, coord_q} + {{ssw_pkg::CoordW{1'b0}}, 1'b1};

  // One counting step, up or down
  always_comb begin
    step_coord = coord_q;
    step_rev   = rev_q;
    wrap       = 1'b0;
    if (ctrl_i.snake && rev_q) begin
      if (coord_q == '0) begin
        step_rev = 1'b0;
        wrap     = 1'b1;
      end else begin
        // downward count clamps to one below the current limit
        step_coord = (dec > lim_m1) ? lim_m1 : dec;
      end
    end else if (inc >= {1'b0, limit_i}) begin
      wrap = 1'b1;
      if (ctrl_i.snake) begin
        step_rev   = 1'b1;
        step_coord = lim_m1;
      end else begin
        step_coord = '0;
      end
    end else begin
      step_coord = inc[ssw_pkg::CoordW-1:0];
    end
  end

  // Next state: restart, step, then end-of-walk parking
  always_comb begin
    coord_d = coord_q;
    rev_d   = rev_q;
    if (ctrl_i.clear) begin
      coord_d = '0;
      rev_d   = 1'b0;
    end else if (ctrl_i.step) begin
      coord_d = ctrl_i.load_end ? limit_i : step_coord;
      rev_d   = step_rev;
    end
  end

  assign carry_o      = ctrl_i.step & wrap;
  assign coord_next_o = coord_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
      rev_q   <= 1'b0;
    end else begin
      coord_q <= coord_d;
      rev_q   <= rev_d;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_snake_slice_walker_core.sv =====
// ----------------------------------------------------------------------------
// tb_snake_slice_walker_core - self-checking bench for the snake slice walker
// Drives restart/advance words through the valid/ready input channel, writes
// the walk registers between phases, and predicts every result word with an
// independent model of the serpentine counter chain. Results are checked in
// order, field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_snake_slice_walker_core;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned TargetWords = 1900;
  localparam int unsigned QuietAfter  = 1600;  // no idling past this many words
  localparam int unsigned HoldCycles  = 90;

  // One result word as seen on the output channel
  typedef struct packed {
    ssw_pkg::coord_t c_first;
    ssw_pkg::coord_t c_second;
    ssw_pkg::coord_t c_third;
    ssw_pkg::coord_t c_fourth;
    ssw_pkg::coord_t c_common;
    logic            changed;
    logic            ended;
  } walk_pos_t;

  // Walk predictor and in-order result checker
  class walk_scoreboard;
    logic [ssw_pkg::CfgDataW-1:0] regs [8];
    int unsigned pos_cnt [5];   // 0..3 dimension counters, 4 is the common counter
    bit          turn_down [5];
    bit          walk_over;
    walk_pos_t   expected_pos_q [$];
    int unsigned mismatches, checked, ended_seen, changed_seen, restarts;

    function new();
      regs[ssw_pkg::REG_NUM_DIMS]     = ssw_pkg::CfgDataW'(2);
      regs[ssw_pkg::REG_LIMIT_FIRST]  = ssw_pkg::CfgDataW'(1);
      regs[ssw_pkg::REG_LIMIT_SECOND] = ssw_pkg::CfgDataW'(1);
      regs[ssw_pkg::REG_LIMIT_THIRD]  = ssw_pkg::CfgDataW'(1);
      regs[ssw_pkg::REG_LIMIT_FOURTH] = ssw_pkg::CfgDataW'(1);
      regs[ssw_pkg::REG_COMMON_LIMIT] = ssw_pkg::CfgDataW'(1);
      regs[ssw_pkg::REG_SNAKE_ENABLE] = ssw_pkg::CfgDataW'(0);
      regs[ssw_pkg::REG_CHANGE_POS]   = ssw_pkg::CfgDataW'(1);
      rewind();
    endfunction

    function void rewind();
      for (int i = 0; i < 5; i++) begin
        pos_cnt[i]   = 0;
        turn_down[i] = 1'b0;
      end
      walk_over = 1'b0;
    endfunction

    function void write_reg(ssw_pkg::reg_idx_e idx, logic [ssw_pkg::CfgDataW-1:0] d);
      case (idx)
        ssw_pkg::REG_NUM_DIMS, ssw_pkg::REG_CHANGE_POS: regs[idx] = {8'd0, d[2:0]};
        ssw_pkg::REG_SNAKE_ENABLE:                      regs[idx] = {10'd0, d[0]};
        default:                                        regs[idx] = d;
      endcase
    endfunction

    function int unsigned sat_limit(int unsigned v);
      if (v < 1) return 1;
      if (v > ssw_pkg::MaxSlices) return ssw_pkg::MaxSlices;
      return v;
    endfunction

    function int unsigned dims_in_use();
      int unsigned n;
      n = regs[ssw_pkg::REG_NUM_DIMS];
      if (n < 1) n = 1;
      if (n > ssw_pkg::MaxDims) n = ssw_pkg::MaxDims;
      return n;
    endfunction

    // Step counter k; returns 1 when it wraps and carries onward
    function bit advance_counter(int k, int unsigned lim, bit serp);
      if (serp && turn_down[k]) begin
        if (pos_cnt[k] == 0) begin
          turn_down[k] = 1'b0;
          return 1'b1;
        end
        pos_cnt[k] = pos_cnt[k] - 1;
        if (pos_cnt[k] > lim - 1) pos_cnt[k] = lim - 1;
        return 1'b0;
      end
      if (pos_cnt[k] + 1 >= lim) begin
        if (serp) begin
          turn_down[k] = 1'b1;
          pos_cnt[k]   = lim - 1;
        end else begin
          pos_cnt[k] = 0;
        end
        return 1'b1;
      end
      pos_cnt[k] = pos_cnt[k] + 1;
      return 1'b0;
    endfunction

    // Accepted input word: advance the walk and queue the resulting position
    function void note_word(bit restart);
      int unsigned n, clim, lim;
      bit serp, chg, all_wrapped;
      walk_pos_t p;
      n   = dims_in_use();
      chg = 1'b0;
      if (restart) begin
        rewind();
        restarts++;
      end else if (!walk_over) begin
        serp = regs[ssw_pkg::REG_SNAKE_ENABLE][0] && n >= 2;
        clim = sat_limit(regs[ssw_pkg::REG_COMMON_LIMIT]);
        chg  = clim > 1;
        if (advance_counter(4, clim, serp)) begin
          all_wrapped = 1'b1;
          for (int i = 0; i < n; i++) begin
            lim = sat_limit(regs[ssw_pkg::REG_LIMIT_FIRST + i]);
            if (regs[ssw_pkg::REG_CHANGE_POS] == i) chg = 1'b1;
            if (!advance_counter(i, lim, (i == 0) ? serp : 1'b0)) begin
              all_wrapped = 1'b0;
              break;
            end
          end
          // every counter wrapped: park at the limits
          if (all_wrapped) begin
            pos_cnt[4] = clim;
            for (int i = 0; i < n; i++)
              pos_cnt[i] = sat_limit(regs[ssw_pkg::REG_LIMIT_FIRST + i]);
            walk_over = 1'b1;
          end
        end
      end
      p.c_first  = ssw_pkg::coord_t'(pos_cnt[0]);
      p.c_second = (n > 1) ? ssw_pkg::coord_t'(pos_cnt[1]) : '0;
      p.c_third  = (n > 2) ? ssw_pkg::coord_t'(pos_cnt[2]) : '0;
      p.c_fourth = (n > 3) ? ssw_pkg::coord_t'(pos_cnt[3]) : '0;
      p.c_common = ssw_pkg::coord_t'(pos_cnt[4]);
      p.changed  = chg;
      p.ended    = walk_over;
      expected_pos_q.insert(expected_pos_q.size(), p);
    endfunction

    function string show(walk_pos_t p);
      return $sformatf("first=%0d second=%0d third=%0d fourth=%0d common=%0d chg=%0b end=%0b",
                       p.c_first, p.c_second, p.c_third, p.c_fourth, p.c_common,
                       p.changed, p.ended);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $time, what);
    endfunction

    // Accepted result word: compare against the oldest expectation
    function void check_word(walk_pos_t got);
      walk_pos_t exp_pos;
      if (expected_pos_q.size() == 0) begin
        report({"result word with nothing expected: ", show(got)});
        return;
      end
      exp_pos = expected_pos_q.pop_front();
      checked++;
      if (got.ended === 1'b1) ended_seen++;
      if (got.changed === 1'b1) changed_seen++;
      if (got.c_first !== exp_pos.c_first || got.c_second !== exp_pos.c_second ||
          got.c_third !== exp_pos.c_third || got.c_fourth !== exp_pos.c_fourth ||
          got.c_common !== exp_pos.c_common || got.changed !== exp_pos.changed ||
          got.ended !== exp_pos.ended)
        report({"mismatch\n  expected ", show(exp_pos), "\n  actual   ", show(got)});
    endfunction

    function int unsigned pending();
      return expected_pos_q.size();
    endfunction

    function void close_out();
      if (expected_pos_q.size() != 0)
        report($sformatf("%0d expected result words never arrived", expected_pos_q.size()));
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [ssw_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ssw_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         restart_walk_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  ssw_pkg::coord_t              coord_first_o, coord_second_o, coord_third_o, coord_fourth_o;
  ssw_pkg::coord_t              common_coord_o;
  logic                         slice_changed_o, walk_ended_o;

  walk_scoreboard sb = new();
  int unsigned    sent_words = 0;
  int unsigned    settings_loaded = 0;
  int unsigned    cycle_count = 0;
  bit             quiet_tail = 1'b0;
  bit             hold_req = 1'b0;

  snake_slice_walker_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .restart_walk_i  (restart_walk_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .coord_first_o   (coord_first_o),
    .coord_second_o  (coord_second_o),
    .coord_third_o   (coord_third_o),
    .coord_fourth_o  (coord_fourth_o),
    .common_coord_o  (common_coord_o),
    .slice_changed_o (slice_changed_o),
    .walk_ended_o    (walk_ended_o)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(walk_pos_t'({coord_first_o, coord_second_o, coord_third_o,
                                 coord_fourth_o, common_coord_o, slice_changed_o,
                                 walk_ended_o}));
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the tail
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      if (quiet_tail) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Offer one input word; valid stays up until it is taken
  task automatic send_word(bit restart);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    restart_walk_i <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    sent_words++;
    sb.note_word(restart);
  endtask

  task automatic write_reg(ssw_pkg::reg_idx_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= ssw_pkg::CfgDataW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, ssw_pkg::CfgDataW'(val));
  endtask

  // Drain the block, then rewrite every register; walk state is kept
  task automatic load_setting(int unsigned dims, int unsigned lim1, int unsigned lim2,
                              int unsigned lim3, int unsigned lim4, int unsigned clim,
                              int unsigned snake, int unsigned chg);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    write_reg(ssw_pkg::REG_NUM_DIMS, dims);
    write_reg(ssw_pkg::REG_LIMIT_FIRST, lim1);
    write_reg(ssw_pkg::REG_LIMIT_SECOND, lim2);
    write_reg(ssw_pkg::REG_LIMIT_THIRD, lim3);
    write_reg(ssw_pkg::REG_LIMIT_FOURTH, lim4);
    write_reg(ssw_pkg::REG_COMMON_LIMIT, clim);
    write_reg(ssw_pkg::REG_SNAKE_ENABLE, snake);
    write_reg(ssw_pkg::REG_CHANGE_POS, chg);
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  function automatic int unsigned pick_limit();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return ssw_pkg::MaxSlices;
      2:       return $urandom_range(ssw_pkg::MaxSlices + 1, 2047);
      3:       return $urandom_range(6, 40);
      default: return $urandom_range(1, 5);
    endcase
  endfunction

  initial begin
    int unsigned dims, chg, phase_len, phase_idx;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults end at once, advance past the end, restart
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);

    // Four dims, snake on, change flag on the first counter: a full short walk
    load_setting(4, 2, 1, 1, 2, 2, 1, 0);
    send_word(1'b1);
    repeat (9) send_word(1'b0);

    // Common counter runs up, turns round and comes down
    load_setting(2, 3, 2, 1, 1, 6, 1, 1);
    send_word(1'b1);
    repeat (7) send_word(1'b0);

    // Shrink the common limit mid-walk with snake off: upward wrap past the limit
    load_setting(2, 3, 2, 1, 1, 3, 0, 1);
    repeat (2) send_word(1'b0);
    // snake back on with the direction flags kept
    load_setting(2, 3, 2, 1, 1, 3, 1, 1);
    repeat (2) send_word(1'b0);

    // Out-of-range registers: zero dims, zero and oversized limits, no change slot
    load_setting(0, 2047, 0, 2047, 0, 0, 1, 7);
    send_word(1'b0);
    load_setting(7, ssw_pkg::MaxSlices, ssw_pkg::MaxSlices, ssw_pkg::MaxSlices,
                 ssw_pkg::MaxSlices, ssw_pkg::MaxSlices, 1, 4);
    send_word(1'b1);
    send_word(1'b0);

    // Random phases: fresh register setting, then a stretch of walk words
    phase_idx = 0;
    while (sent_words < TargetWords) begin
      case ($urandom_range(0, 7))
        0:       dims = 0;
        1:       dims = $urandom_range(5, 7);
        default: dims = $urandom_range(1, 4);
      endcase
      case ($urandom_range(0, 9))
        8:       chg = 4;
        9:       chg = $urandom_range(5, 7);
        default: chg = $urandom_range(0, 3);
      endcase
      load_setting(dims, pick_limit(), pick_limit(), pick_limit(), pick_limit(),
                   pick_limit(), ($urandom_range(0, 2) != 0), chg);
      phase_idx++;
      if (phase_idx == 3) hold_req = 1'b1;
      if ($urandom_range(0, 2) == 0) send_word(1'b1);
      phase_len = $urandom_range(30, 110);
      for (int k = 0; k < phase_len && sent_words < TargetWords; k++) begin
        if (sent_words >= QuietAfter) quiet_tail = 1'b1;
        if (sb.walk_over) send_word(1'($urandom_range(0, 1)));
        else send_word($urandom_range(0, 59) == 0);
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    sb.close_out();

    $display("walk run: %0d input words over %0d register settings, %0d restarts",
             sent_words, settings_loaded, sb.restarts);
    $display("results checked: %0d (%0d at walk end, %0d slice changes), %0d mismatches",
             sb.checked, sb.ended_seen, sb.changed_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
